FILE: sv/lottery_ticket_scheduler_top_assert.svh
// assertion macros for the lottery ticket scheduler
`ifndef LOTTERY_TICKET_SCHEDULER_TOP_ASSERT_SVH
`define LOTTERY_TICKET_SCHEDULER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define LTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lottery scheduler assertion failed");
// antecedent implies consequent in the next cycle
`define LTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lottery scheduler assertion failed");
`else
`define LTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define LTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/lts_pkg.sv
// shared types and codes of the lottery ticket scheduler
`default_nettype none
package lts_pkg;

  localparam int unsigned SUM_W = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;
  localparam logic [16:0] TICKET_MAX = 17'h0FFFF;
  localparam int unsigned RND_W = 31;

  typedef enum logic [2:0] {
    MODE_INSERT  = 3'd0,
    MODE_REMOVE  = 3'd1,
    MODE_XFER    = 3'd2,
    MODE_INFLATE = 3'd3,
    MODE_DEFLATE = 3'd4,
    MODE_DRAW    = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_FULL           = 4'd1,
    ST_BAD_AMOUNT     = 4'd2,
    ST_NOT_FOUND      = 4'd3,
    ST_TARGET_MISSING = 4'd4,
    ST_INSUFFICIENT   = 4'd5,
    ST_WRONG_DIR      = 4'd6,
    ST_NO_TICKETS     = 4'd7,
    ST_OVERFLOW       = 4'd8
  } status_e;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] tickets;
    logic [31:0] wins;
  } entry_t;

endpackage
`default_nettype wire

FILE: sv/lts_if.sv
// request and response channel interfaces
`default_nettype none
interface lts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] pid;
  logic [15:0] other_pid;
  logic [15:0] amount;
  logic [30:0] random_value;
  modport source (output valid, mode, pid, other_pid, amount, random_value, input ready);
  modport sink (input valid, mode, pid, other_pid, amount, random_value, output ready);
endinterface

interface lts_rsp_if #(parameter int unsigned CNT_W = 5);
  logic             valid;
  logic             ready;
  logic [3:0]       status;
  logic [15:0]      winner_pid;
  logic [31:0]      winner_wins;
  logic [19:0]      total_tickets;
  logic [CNT_W-1:0] process_count;
  modport source (output valid, status, winner_pid, winner_wins, total_tickets,
                  process_count, input ready);
  modport sink (input valid, status, winner_pid, winner_wins, total_tickets,
                process_count, output ready);
endinterface
`default_nettype wire

FILE: sv/lottery_ticket_scheduler_top.sv
// lottery ticket scheduler: process table in one memory, request sequencer
// usage
//   req_i carries one request: mode, pid, other_pid, amount, random_value.
//   rsp_o returns one response per request: status, winner_pid, winner_wins,
//   total_tickets and process_count after the request.
//   the table lives in a synchronous memory (registered read); every
//   table lookup reads entries from newest to oldest.
// sequence
//   insert or unknown mode: straight to execute, no lookup; remove,
//   transfer, inflate, deflate: a table lookup, remove then moves each
//   later entry down by one; draw: the bit-serial remainder of
//   random_value by the ticket total, then a lookup.
// throughput: one request at a time; a new request is taken as soon as the
//   sequencer is back in idle, even while the last response still waits.
// reset: the entry count and ticket total clear at once, the memory itself
//   is not cleared (only entries below the count are ever read).
// stall: a finished response waits in the sequencer until the output
//   register is free; the output register holds until rsp_o.ready.
`default_nettype none
module lottery_ticket_scheduler_top #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lts_req_if.sink   req_i,
  lts_rsp_if.source rsp_o
);
  import lts_pkg::*;

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(NUM_SLOTS);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_RD   = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_EXEC = 9'b000010000,
    S_SHRD = 9'b000100000,
    S_SHWR = 9'b001000000,
    S_WRB  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] pid;
    logic [15:0] other_pid;
    logic [15:0] amount;
  } req_t;

  // process table
  entry_t mem [NUM_SLOTS];
  entry_t rd_q;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  // lookup results: newest match of pid (a) and of other_pid (b)
  logic             fa_q, fa_d, fb_q, fb_d;
  logic [IDX_W-1:0] a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  entry_t           a_ent_q, a_ent_d, b_ent_q, b_ent_d;
  // draw remainder and running ticket sum
  logic [RND_W-1:0] dsh_q, dsh_d;
  logic [SUM_W-1:0] rem_q, rem_d, run_q, run_d;
  logic [4:0]       dcnt_q, dcnt_d;
  // pending response
  status_e          res_st_q, res_st_d;
  logic [15:0]      res_pid_q, res_pid_d;
  logic [31:0]      res_wins_q, res_wins_d;
  // output register
  logic             ovld_q;
  logic             oload;
  logic [3:0]       ost_q;
  logic [15:0]      opid_q;
  logic [31:0]      owins_q;
  logic [SUM_W-1:0] osum_q;
  logic [CNT_W-1:0] ocnt_q;

  logic [SUM_W:0]   div_t, sum_plus, infl_sum;
  logic [SUM_W-1:0] run_sum;
  logic [16:0]      b_plus;
  logic             hit_a, hit_b;
  logic             accept;

  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[idx_q];
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    count_d    = count_q;
    sum_d      = sum_q;
    idx_d      = idx_q;
    fa_d       = fa_q;
    fb_d       = fb_q;
    a_idx_d    = a_idx_q;
    b_idx_d    = b_idx_q;
    a_ent_d    = a_ent_q;
    b_ent_d    = b_ent_q;
    dsh_d      = dsh_q;
    rem_d      = rem_q;
    run_d      = run_q;
    dcnt_d     = dcnt_q;
    res_st_d   = res_st_q;
    res_pid_d  = res_pid_q;
    res_wins_d = res_wins_q;
    we         = 1'b0;
    wa         = a_idx_q;
    wd         = a_ent_q;
    oload      = 1'b0;
    hit_a      = 1'b0;
    hit_b      = 1'b0;
    div_t      = {rem_q, dsh_q[RND_W-1]};
    run_sum    = run_q + rd_q.tickets;
    sum_plus   = {1'b0, sum_q} + {5'd0, req_q.amount};
    infl_sum   = {1'b0, sum_q} - {5'd0, a_ent_q.tickets} + {5'd0, req_q.amount};
    b_plus     = {1'b0, b_ent_q.tickets} + {1'b0, req_q.amount};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d      = '{mode: req_i.mode, pid: req_i.pid,
                         other_pid: req_i.other_pid, amount: req_i.amount};
          fa_d       = 1'b0;
          fb_d       = 1'b0;
          run_d      = '0;
          rem_d      = '0;
          dsh_d      = req_i.random_value;
          dcnt_d     = 5'(RND_W - 1);
          idx_d      = IDX_W'(count_q - 1'b1);
          res_st_d   = ST_OK;
          res_pid_d  = '0;
          res_wins_d = '0;
          if (req_i.mode == MODE_DRAW && sum_q != '0) begin
            state_d = S_DIV;
          end else if ((req_i.mode == MODE_REMOVE || req_i.mode == MODE_XFER ||
                        req_i.mode == MODE_INFLATE || req_i.mode == MODE_DEFLATE) &&
                       count_q != '0) begin
            state_d = S_RD;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_DIV: begin
        // restoring remainder, one bit per cycle
        rem_d = (div_t >= {1'b0, sum_q}) ? SUM_W'(div_t - {1'b0, sum_q}) : div_t[SUM_W-1:0];
        dsh_d = dsh_q << 1;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (req_q.mode == MODE_DRAW) begin
          run_d = run_sum;
          if (run_sum > rem_q) begin
            fa_d    = 1'b1;
            a_idx_d = idx_q;
            a_ent_d = rd_q;
            state_d = S_EXEC;
          end else if (idx_q == '0) begin
            state_d = S_EXEC;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_RD;
          end
        end else begin
          hit_a = !fa_q && (rd_q.pid == req_q.pid);
          hit_b = !fb_q && (rd_q.pid == req_q.other_pid);
          if (hit_a) begin
            fa_d    = 1'b1;
            a_idx_d = idx_q;
            a_ent_d = rd_q;
          end
          if (hit_b) begin
            fb_d    = 1'b1;
            b_idx_d = idx_q;
            b_ent_d = rd_q;
          end
          if ((fa_d && (req_q.mode != MODE_XFER || fb_d)) || idx_q == '0) begin
            state_d = S_EXEC;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (req_q.mode)
          MODE_INSERT: begin
            if (req_q.amount == '0) begin
              res_st_d = ST_BAD_AMOUNT;
            end else if (count_q >= SLOTS) begin
              res_st_d = ST_FULL;
            end else if (sum_plus > {1'b0, SUM_MAX}) begin
              res_st_d = ST_OVERFLOW;
            end else begin
              we      = 1'b1;
              wa      = IDX_W'(count_q);
              wd      = '{pid: req_q.pid, tickets: req_q.amount, wins: '0};
              count_d = count_q + 1'b1;
              sum_d   = sum_plus[SUM_W-1:0];
            end
          end
          MODE_REMOVE: begin
            if (!fa_q) begin
              res_st_d = ST_NOT_FOUND;
            end else begin
              sum_d = sum_q - a_ent_q.tickets;
              if (CNT_W'(a_idx_q) + 1'b1 < count_q) begin
                idx_d   = a_idx_q + 1'b1;
                state_d = S_SHRD;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
          end
          MODE_XFER: begin
            if (!fa_q) begin
              res_st_d = ST_NOT_FOUND;
            end else if (!fb_q) begin
              res_st_d = ST_TARGET_MISSING;
            end else if (req_q.amount == '0) begin
              res_st_d = ST_BAD_AMOUNT;
            end else if (a_ent_q.tickets < req_q.amount) begin
              res_st_d = ST_INSUFFICIENT;
            end else if (a_idx_q != b_idx_q) begin
              if (b_plus > TICKET_MAX) begin
                res_st_d = ST_OVERFLOW;
              end else begin
                we         = 1'b1;
                wd.tickets = a_ent_q.tickets - req_q.amount;
                state_d    = S_WRB;
              end
            end
          end
          MODE_INFLATE, MODE_DEFLATE: begin
            if (!fa_q) begin
              res_st_d = ST_NOT_FOUND;
            end else if (req_q.amount == '0) begin
              res_st_d = ST_BAD_AMOUNT;
            end else if (req_q.mode == MODE_INFLATE && req_q.amount <= a_ent_q.tickets) begin
              res_st_d = ST_WRONG_DIR;
            end else if (req_q.mode == MODE_DEFLATE && req_q.amount >= a_ent_q.tickets) begin
              res_st_d = ST_WRONG_DIR;
            end else if (infl_sum > {1'b0, SUM_MAX}) begin
              res_st_d = ST_OVERFLOW;
            end else begin
              we         = 1'b1;
              wd.tickets = req_q.amount;
              sum_d      = infl_sum[SUM_W-1:0];
            end
          end
          MODE_DRAW: begin
            if (sum_q == '0) begin
              res_st_d = ST_NO_TICKETS;
            end else if (fa_q) begin
              we = 1'b1;
              if (a_ent_q.wins != 32'hFFFF_FFFF) begin
                wd.wins = a_ent_q.wins + 1'b1;
              end
              res_pid_d  = a_ent_q.pid;
              res_wins_d = wd.wins;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHRD: begin
        state_d = S_SHWR;
      end
      S_SHWR: begin
        // close the gap: entry idx moves down by one
        we = 1'b1;
        wa = idx_q - 1'b1;
        wd = rd_q;
        if (CNT_W'(idx_q) + 1'b1 < count_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SHRD;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end
      S_WRB: begin
        we         = 1'b1;
        wa         = b_idx_q;
        wd         = b_ent_q;
        wd.tickets = b_plus[15:0];
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!ovld_q || rsp_o.ready) begin
          oload   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      if (oload) begin
        ovld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    fa_q       <= fa_d;
    fb_q       <= fb_d;
    a_idx_q    <= a_idx_d;
    b_idx_q    <= b_idx_d;
    a_ent_q    <= a_ent_d;
    b_ent_q    <= b_ent_d;
    dsh_q      <= dsh_d;
    rem_q      <= rem_d;
    run_q      <= run_d;
    dcnt_q     <= dcnt_d;
    res_st_q   <= res_st_d;
    res_pid_q  <= res_pid_d;
    res_wins_q <= res_wins_d;
    if (oload) begin
      ost_q   <= res_st_q;
      opid_q  <= res_pid_q;
      owins_q <= res_wins_q;
      osum_q  <= sum_q;
      ocnt_q  <= count_q;
    end
  end

  assign rsp_o.valid         = ovld_q;
  assign rsp_o.status        = ost_q;
  assign rsp_o.winner_pid    = opid_q;
  assign rsp_o.winner_wins   = owins_q;
  assign rsp_o.total_tickets = osum_q;
  assign rsp_o.process_count = ocnt_q;

`include "lottery_ticket_scheduler_top_assert.svh"
  `LTS_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= SLOTS)
  `LTS_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, accept, state_q != S_IDLE)
  `LTS_ASSERT_IMPL(a_no_write_idle, clk_i, rst_ni, state_q == S_IDLE, !we)
  `LTS_ASSERT_NEXT(a_idle_holds_count, clk_i, rst_ni, state_q == S_IDLE, $stable(count_q))
  `LTS_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, oload, !ovld_q || rsp_o.ready)

endmodule
`default_nettype wire
